>>> design/sip_pkg.sv
// Shared widths, word types and constants for the segment intersection block.
// No dependencies; every other file of the block refers to it by scoped names.
package sip_pkg;

    localparam int CoordW = 32;   // Q16.16 coordinate
    localparam int DiffW  = 33;   // difference of two coordinates
    localparam int ProdW  = 66;   // product of two differences
    localparam int CrossW = 67;   // denominator and numerators
    localparam int DivW   = 68;   // divider remainder and divisor
    localparam int QuoW   = 35;   // quotient bits, one divider stage each
    localparam int TolW   = 30;
    localparam int HiW    = 35;   // upper slice of a numerator
    localparam int HiPW   = 68;   // upper partial product
    localparam int VW     = 100;  // numerator times direction
    localparam int XW     = 104;  // offset dividend of the point division

    // Quotient offsets: the point quotient is biased by 2^34, and the window
    // quotient of (num + den) * 2^30 / den is biased by 2^30.
    localparam logic [QuoW-1:0] QuoOffset = 35'h4_0000_0000;
    localparam logic [QuoW-1:0] LowBase   = 35'h0_4000_0000;
    localparam logic [QuoW-1:0] HighBase  = 35'h0_8000_0000;
    localparam logic [TolW-1:0] TolReset  = 30'd1;

    typedef struct packed {
        logic signed [CoordW-1:0] first_start_x;
        logic signed [CoordW-1:0] first_start_y;
        logic signed [CoordW-1:0] first_end_x;
        logic signed [CoordW-1:0] first_end_y;
        logic signed [CoordW-1:0] second_start_x;
        logic signed [CoordW-1:0] second_start_y;
        logic signed [CoordW-1:0] second_end_x;
        logic signed [CoordW-1:0] second_end_y;
    } sip_in_t;

    typedef struct packed {
        logic                     hit;
        logic                     parallel;
        logic signed [CoordW-1:0] cross_x;
        logic signed [CoordW-1:0] cross_y;
    } sip_out_t;

    typedef struct packed {
        logic [DivW-1:0] rem;
        logic [QuoW-1:0] num;
        logic [DivW-1:0] dvs;
    } sip_div_in_t;

    typedef struct packed {
        logic [QuoW-1:0] quo;
        logic            rem_nz;
    } sip_div_out_t;

    typedef struct packed {
        logic                     par;
        logic                     pre_s;
        logic                     pre_t;
        logic signed [CoordW-1:0] p1x;
        logic signed [CoordW-1:0] p1y;
    } sip_side_t;

    typedef struct packed {
        sip_div_in_t div_s;
        sip_div_in_t div_t;
        sip_div_in_t div_x;
        sip_div_in_t div_y;
        sip_side_t   side;
    } sip_fe_t;

endpackage

>>> design/segment_intersection_point.sv
// Top level of the segment intersection block: tolerance register, front end,
// four divider lanes, side-data delay line and back end. Uses sip_pkg.
//
//  channel   ports                               word
//  input     s_valid / s_ready / s_data          sip_in_t, two segments
//  result    m_valid / m_ready / m_data          sip_out_t, hit, parallel, point
//  config    cfg_wr_en / cfg_wr_data             param_tolerance, 30 bits
//
// One word is taken per cycle while s_ready is high; a result passes through
// seven front-end stages, 35 divider stages (one quotient bit each) and the output register.
// Reset clears every valid bit and sets the tolerance to its reset value.
// While a result word waits on m_ready the whole pipeline holds and s_ready is low.
module segment_intersection_point (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  sip_pkg::sip_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output sip_pkg::sip_out_t             m_data,
    input  logic                          cfg_wr_en,
    input  logic [sip_pkg::TolW-1:0]      cfg_wr_data
);

    logic [sip_pkg::TolW-1:0] tol_reg;
    logic                     en;
    logic                     fe_valid;
    sip_pkg::sip_fe_t         fe_data;
    sip_pkg::sip_div_out_t    q_s, q_t, q_x, q_y;
    logic [sip_pkg::QuoW-1:0] vld_reg;
    sip_pkg::sip_side_t       side_reg [sip_pkg::QuoW];

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= sip_pkg::TolReset;
        end else if (cfg_wr_en) begin
            tol_reg <= cfg_wr_data;
        end
    end

    sip_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fe_valid),
        .out_data  (fe_data)
    );

    sip_div u_div_s (.aclk(aclk), .en(en), .in_data(fe_data.div_s), .out_data(q_s));
    sip_div u_div_t (.aclk(aclk), .en(en), .in_data(fe_data.div_t), .out_data(q_t));
    sip_div u_div_x (.aclk(aclk), .en(en), .in_data(fe_data.div_x), .out_data(q_x));
    sip_div u_div_y (.aclk(aclk), .en(en), .in_data(fe_data.div_y), .out_data(q_y));

    // Flags and start point ride alongside the divider lanes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[sip_pkg::QuoW-2:0], fe_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= fe_data.side;
            for (int k = 1; k < sip_pkg::QuoW; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    sip_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[sip_pkg::QuoW-1]),
        .q_s       (q_s),
        .q_t       (q_t),
        .q_x       (q_x),
        .q_y       (q_y),
        .side      (side_reg[sip_pkg::QuoW-1]),
        .tol       (tol_reg),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

`ifndef NO_ASSERTIONS
    a_hit_not_parallel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.hit |-> !m_data.parallel)
        else $error("hit reported together with parallel");

    a_miss_zero_point: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.hit |-> (m_data.cross_x == '0) && (m_data.cross_y == '0))
        else $error("point not zero on a miss");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word dropped during stall");
`endif

endmodule

>>> design/sip_front.sv
// Front end: differences, cross products, sign normalisation, window pre-check
// and the dividends of the four divider lanes. Seven register stages. Uses sip_pkg.
module sip_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  sip_pkg::sip_in_t  in_data,
    output logic              out_valid,
    output sip_pkg::sip_fe_t  out_data
);

    logic [6:0] vld_reg;

    // stage 1
    logic signed [sip_pkg::DiffW-1:0] s1x_reg, s1y_reg, s2x_reg, s2y_reg, wx_reg, wy_reg;
    logic signed [sip_pkg::CoordW-1:0] p1x1_reg, p1y1_reg;
    // stage 2
    logic signed [sip_pkg::ProdW-1:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [sip_pkg::DiffW-1:0] s1x2_reg, s1y2_reg;
    logic signed [sip_pkg::CoordW-1:0] p1x2_reg, p1y2_reg;
    // stage 3
    logic signed [sip_pkg::CrossW-1:0] den3_reg, sn3_reg, tn3_reg;
    logic signed [sip_pkg::DiffW-1:0] s1x3_reg, s1y3_reg;
    logic signed [sip_pkg::CoordW-1:0] p1x3_reg, p1y3_reg;
    // stage 4
    logic [sip_pkg::CrossW-1:0] den4_reg;
    logic signed [sip_pkg::CrossW-1:0] sn4_reg, tn4_reg;
    logic signed [sip_pkg::DiffW-1:0] s1x4_reg, s1y4_reg;
    logic signed [sip_pkg::CoordW-1:0] p1x4_reg, p1y4_reg;
    logic par4_reg;
    // stage 5
    logic [sip_pkg::CrossW-1:0] den5_reg;
    logic [sip_pkg::DivW-1:0] as5_reg, at5_reg;
    logic pres5_reg, pret5_reg, par5_reg;
    logic signed [sip_pkg::ProdW-1:0] lox_reg, loy_reg;
    logic signed [sip_pkg::HiPW-1:0] hix_reg, hiy_reg;
    logic signed [sip_pkg::CoordW-1:0] p1x5_reg, p1y5_reg;
    // stage 6
    logic [sip_pkg::CrossW-1:0] den6_reg;
    logic [sip_pkg::DivW-1:0] as6_reg, at6_reg;
    logic pres6_reg, pret6_reg, par6_reg;
    logic signed [sip_pkg::VW-1:0] vx_reg, vy_reg;
    logic signed [sip_pkg::CoordW-1:0] p1x6_reg, p1y6_reg;
    // stage 7
    logic [sip_pkg::CrossW-1:0] den7_reg;
    logic [sip_pkg::DivW-1:0] as7_reg, at7_reg;
    logic [sip_pkg::XW-1:0] xx_reg, xy_reg;
    sip_pkg::sip_side_t side7_reg;

    logic neg4;
    logic signed [sip_pkg::CrossW+1:0] sn69, tn69, den69, as69, at69;
    logic [sip_pkg::XW-1:0] den_x, den_off;

    assign neg4  = den3_reg[sip_pkg::CrossW-1];
    assign sn69  = $signed({{2{sn4_reg[sip_pkg::CrossW-1]}}, sn4_reg});
    assign tn69  = $signed({{2{tn4_reg[sip_pkg::CrossW-1]}}, tn4_reg});
    assign den69 = $signed({2'b00, den4_reg});
    assign as69  = sn69 + den69;
    assign at69  = tn69 + den69;
    assign den_x   = {37'd0, den6_reg};
    assign den_off = {2'b00, den6_reg, 35'd0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1x_reg <= $signed({in_data.first_end_x[31], in_data.first_end_x})
                     - $signed({in_data.first_start_x[31], in_data.first_start_x});
            s1y_reg <= $signed({in_data.first_end_y[31], in_data.first_end_y})
                     - $signed({in_data.first_start_y[31], in_data.first_start_y});
            s2x_reg <= $signed({in_data.second_end_x[31], in_data.second_end_x})
                     - $signed({in_data.second_start_x[31], in_data.second_start_x});
            s2y_reg <= $signed({in_data.second_end_y[31], in_data.second_end_y})
                     - $signed({in_data.second_start_y[31], in_data.second_start_y});
            wx_reg  <= $signed({in_data.first_start_x[31], in_data.first_start_x})
                     - $signed({in_data.second_start_x[31], in_data.second_start_x});
            wy_reg  <= $signed({in_data.first_start_y[31], in_data.first_start_y})
                     - $signed({in_data.second_start_y[31], in_data.second_start_y});
            p1x1_reg <= in_data.first_start_x;
            p1y1_reg <= in_data.first_start_y;

            m0_reg <= s1x_reg * s2y_reg;
            m1_reg <= s2x_reg * s1y_reg;
            m2_reg <= s1x_reg * wy_reg;
            m3_reg <= s1y_reg * wx_reg;
            m4_reg <= s2x_reg * wy_reg;
            m5_reg <= s2y_reg * wx_reg;
            s1x2_reg <= s1x_reg;
            s1y2_reg <= s1y_reg;
            p1x2_reg <= p1x1_reg;
            p1y2_reg <= p1y1_reg;

            den3_reg <= $signed({m0_reg[65], m0_reg}) - $signed({m1_reg[65], m1_reg});
            sn3_reg  <= $signed({m2_reg[65], m2_reg}) - $signed({m3_reg[65], m3_reg});
            tn3_reg  <= $signed({m4_reg[65], m4_reg}) - $signed({m5_reg[65], m5_reg});
            s1x3_reg <= s1x2_reg;
            s1y3_reg <= s1y2_reg;
            p1x3_reg <= p1x2_reg;
            p1y3_reg <= p1y2_reg;

            // Make the denominator positive and flip both numerators with it.
            den4_reg <= neg4 ? 67'(-den3_reg) : den3_reg;
            sn4_reg  <= neg4 ? -sn3_reg : sn3_reg;
            tn4_reg  <= neg4 ? -tn3_reg : tn3_reg;
            par4_reg <= (den3_reg == '0);
            s1x4_reg <= s1x3_reg;
            s1y4_reg <= s1y3_reg;
            p1x4_reg <= p1x3_reg;
            p1y4_reg <= p1y3_reg;

            // A position can only be in the window if -den <= num < 2*den.
            den5_reg  <= den4_reg;
            as5_reg   <= as69[sip_pkg::DivW-1:0];
            at5_reg   <= at69[sip_pkg::DivW-1:0];
            pres5_reg <= !as69[sip_pkg::CrossW+1] && (sn69 < (den69 <<< 1));
            pret5_reg <= !at69[sip_pkg::CrossW+1] && (tn69 < (den69 <<< 1));
            par5_reg  <= par4_reg;
            lox_reg <= $signed({1'b0, tn4_reg[31:0]}) * s1x4_reg;
            loy_reg <= $signed({1'b0, tn4_reg[31:0]}) * s1y4_reg;
            hix_reg <= $signed(tn4_reg[sip_pkg::CrossW-1:32]) * s1x4_reg;
            hiy_reg <= $signed(tn4_reg[sip_pkg::CrossW-1:32]) * s1y4_reg;
            p1x5_reg <= p1x4_reg;
            p1y5_reg <= p1y4_reg;

            den6_reg  <= den5_reg;
            as6_reg   <= as5_reg;
            at6_reg   <= at5_reg;
            pres6_reg <= pres5_reg;
            pret6_reg <= pret5_reg;
            par6_reg  <= par5_reg;
            vx_reg <= $signed({hix_reg, 32'd0}) + $signed({{34{lox_reg[65]}}, lox_reg});
            vy_reg <= $signed({hiy_reg, 32'd0}) + $signed({{34{loy_reg[65]}}, loy_reg});
            p1x6_reg <= p1x5_reg;
            p1y6_reg <= p1y5_reg;

            // Rounded quotient as floor((2v + den) / (2 den)), biased by 2^34.
            den7_reg <= den6_reg;
            as7_reg  <= as6_reg;
            at7_reg  <= at6_reg;
            xx_reg   <= {{3{vx_reg[99]}}, vx_reg, 1'b0} + den_x + den_off;
            xy_reg   <= {{3{vy_reg[99]}}, vy_reg, 1'b0} + den_x + den_off;
            side7_reg.par   <= par6_reg;
            side7_reg.pre_s <= pres6_reg;
            side7_reg.pre_t <= pret6_reg;
            side7_reg.p1x   <= p1x6_reg;
            side7_reg.p1y   <= p1y6_reg;
        end
    end

    assign out_valid = vld_reg[6];

    assign out_data.div_s.dvs = {1'b0, den7_reg};
    assign out_data.div_s.rem = {5'd0, as7_reg[sip_pkg::DivW-1:5]};
    assign out_data.div_s.num = {as7_reg[4:0], 30'd0};
    assign out_data.div_t.dvs = {1'b0, den7_reg};
    assign out_data.div_t.rem = {5'd0, at7_reg[sip_pkg::DivW-1:5]};
    assign out_data.div_t.num = {at7_reg[4:0], 30'd0};
    assign out_data.div_x.dvs = {den7_reg, 1'b0};
    assign out_data.div_x.rem = xx_reg[102:35];
    assign out_data.div_x.num = xx_reg[34:0];
    assign out_data.div_y.dvs = {den7_reg, 1'b0};
    assign out_data.div_y.rem = xy_reg[102:35];
    assign out_data.div_y.num = xy_reg[34:0];
    assign out_data.side      = side7_reg;

    // Top bits of the point dividends are zero whenever the result is used.
    logic unused_top;
    assign unused_top = xx_reg[103] ^ xy_reg[103];

endmodule

>>> design/sip_div.sv
// Pipelined restoring divider lane: one quotient bit per register stage.
// Uses sip_pkg for widths and the lane word types.
module sip_div (
    input  logic                  aclk,
    input  logic                  en,
    input  sip_pkg::sip_div_in_t  in_data,
    output sip_pkg::sip_div_out_t out_data
);

    logic [sip_pkg::DivW-1:0] rem_reg [sip_pkg::QuoW];
    logic [sip_pkg::DivW-1:0] dvs_reg [sip_pkg::QuoW];
    logic [sip_pkg::QuoW-1:0] num_reg [sip_pkg::QuoW];
    logic [sip_pkg::QuoW-1:0] quo_reg [sip_pkg::QuoW];

    for (genvar k = 0; k < sip_pkg::QuoW; k++) begin : g_step
        logic [sip_pkg::DivW-1:0] r_in, d_in, shifted;
        logic [sip_pkg::QuoW-1:0] n_in, q_in;
        logic                     ge;

        if (k == 0) begin : g_first
            assign r_in = in_data.rem;
            assign d_in = in_data.dvs;
            assign n_in = in_data.num;
            assign q_in = '0;
        end else begin : g_rest
            assign r_in = rem_reg[k-1];
            assign d_in = dvs_reg[k-1];
            assign n_in = num_reg[k-1];
            assign q_in = quo_reg[k-1];
        end

        // Bring down the next dividend bit and subtract where it fits.
        assign shifted = {r_in[sip_pkg::DivW-2:0], n_in[sip_pkg::QuoW-1]};
        assign ge      = (shifted >= d_in);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? shifted - d_in : shifted;
                dvs_reg[k] <= d_in;
                num_reg[k] <= {n_in[sip_pkg::QuoW-2:0], 1'b0};
                quo_reg[k] <= {q_in[sip_pkg::QuoW-2:0], ge};
            end
        end
    end

    assign out_data.quo    = quo_reg[sip_pkg::QuoW-1];
    assign out_data.rem_nz = |rem_reg[sip_pkg::QuoW-1];

    logic unused_tail;
    assign unused_tail = ^{num_reg[sip_pkg::QuoW-1], dvs_reg[sip_pkg::QuoW-1]};

endmodule

>>> design/sip_back.sv
// Back end: window tests on the two position quotients, point rounding and
// saturation, and the output register. Uses sip_pkg.
module sip_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         en,
    input  logic                         in_valid,
    input  sip_pkg::sip_div_out_t        q_s,
    input  sip_pkg::sip_div_out_t        q_t,
    input  sip_pkg::sip_div_out_t        q_x,
    input  sip_pkg::sip_div_out_t        q_y,
    input  sip_pkg::sip_side_t           side,
    input  logic [sip_pkg::TolW-1:0]     tol,
    output logic                         out_valid,
    output sip_pkg::sip_out_t            out_data
);

    logic                 m_valid_reg;
    sip_pkg::sip_out_t    m_data_reg;
    sip_pkg::sip_out_t    m_data_next;
    logic                 in_s, in_t, hit;

    // q is floor((num + den) * 2^30 / den); the window is [2^30 - tol, 2^31 + tol].
    function automatic logic in_window(input logic [sip_pkg::QuoW-1:0] q,
                                       input logic nz, input logic pre,
                                       input logic [sip_pkg::TolW-1:0] t);
        logic [sip_pkg::QuoW-1:0] lo_b;
        logic [sip_pkg::QuoW-1:0] hi_b;
        lo_b = sip_pkg::LowBase - {5'd0, t};
        hi_b = sip_pkg::HighBase + {5'd0, t};
        return pre && (q >= lo_b) && ((q < hi_b) || ((q == hi_b) && !nz));
    endfunction

    function automatic logic [sip_pkg::CoordW-1:0] point(
            input logic [sip_pkg::QuoW-1:0] q, input logic signed [sip_pkg::CoordW-1:0] p);
        logic signed [36:0] sum;
        sum = $signed({2'b00, q}) - $signed({2'b00, sip_pkg::QuoOffset})
            + $signed({{5{p[31]}}, p});
        if (sum[36:31] == 6'b000000 || sum[36:31] == 6'b111111) begin
            return sum[31:0];
        end else if (sum[36]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

    assign in_s = in_window(q_s.quo, q_s.rem_nz, side.pre_s, tol);
    assign in_t = in_window(q_t.quo, q_t.rem_nz, side.pre_t, tol);
    assign hit  = !side.par && in_s && in_t;

    always_comb begin
        m_data_next.hit      = hit;
        m_data_next.parallel = side.par;
        m_data_next.cross_x  = hit ? point(q_x.quo, side.p1x) : '0;
        m_data_next.cross_y  = hit ? point(q_y.quo, side.p1y) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign out_valid = m_valid_reg;
    assign out_data  = m_data_reg;

    logic unused_nz;
    assign unused_nz = q_x.rem_nz ^ q_y.rem_nz;

endmodule

>>> dv/tb_segment_intersection_point.sv
// Testbench for segment_intersection_point: directed table, then random segment pairs.
// Each result word is checked against the table's expected word or an in-bench intersection predictor. Uses sip_pkg.
module tb_segment_intersection_point;

    typedef logic signed [159:0] wide_t;

    typedef struct {
        sip_pkg::sip_in_t  w;
        bit                typed;
        sip_pkg::sip_out_t res;
    } stim_row_t;

    localparam int Q1       = 32'h0001_0000;
    localparam int MaxC     = 32'h7FFF_FFFF;
    localparam int MinC     = 32'h8000_0000;
    localparam int WdLimit  = 4000;
    localparam int HoldLen  = 300;
    localparam int DrainLen = 60;

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    sip_pkg::sip_in_t          s_data;
    logic                      m_valid;
    logic                      m_ready;
    sip_pkg::sip_out_t         m_data;
    logic                      cfg_wr_en;
    logic [sip_pkg::TolW-1:0]  cfg_wr_data;

    logic [sip_pkg::TolW-1:0]  tolerance;
    sip_pkg::sip_out_t         pending_points[$];
    stim_row_t                 stim_table[$];
    int                        mismatches;
    int                        words_out;
    int                        idle_cycles;
    bit                        held;
    int                        hold_left;

    segment_intersection_point dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic wide_t floor_div(wide_t n, wide_t d);
        wide_t q;
        q = n / d;
        if (n < 0 && q * d != n) q = q - 1;
        return q;
    endfunction

    // Exact rational test of num/den against [-tol, 1 + tol], den positive.
    function automatic bit within_window(wide_t num, wide_t den, wide_t tol);
        wide_t lhs;
        lhs = num <<< 30;
        return (lhs >= -(tol * den)) && (lhs <= ((wide_t'(1) <<< 30) + tol) * den);
    endfunction

    // Rounds tn*dir/den to the nearest Q16.16 step, ties upward, then saturates.
    function automatic logic [31:0] point_coord(wide_t base, wide_t tn, wide_t dir, wide_t den);
        wide_t v;
        v = base + floor_div(((tn * dir) <<< 1) + den, den <<< 1);
        if (v > wide_t'(32'sh7FFF_FFFF)) v = wide_t'(32'sh7FFF_FFFF);
        if (v < -(wide_t'(1) <<< 31)) v = -(wide_t'(1) <<< 31);
        return v[31:0];
    endfunction

    function automatic sip_pkg::sip_out_t predict_crossing(sip_pkg::sip_in_t w,
                                                           logic [sip_pkg::TolW-1:0] tol_q30);
        wide_t p1x, p1y, s1x, s1y, s2x, s2y, wx, wy, den, sn, tn, tol;
        sip_pkg::sip_out_t r;
        p1x = $signed(w.first_start_x);
        p1y = $signed(w.first_start_y);
        s1x = wide_t'($signed(w.first_end_x)) - p1x;
        s1y = wide_t'($signed(w.first_end_y)) - p1y;
        s2x = wide_t'($signed(w.second_end_x)) - wide_t'($signed(w.second_start_x));
        s2y = wide_t'($signed(w.second_end_y)) - wide_t'($signed(w.second_start_y));
        wx  = p1x - wide_t'($signed(w.second_start_x));
        wy  = p1y - wide_t'($signed(w.second_start_y));
        den = s1x * s2y - s2x * s1y;
        sn  = s1x * wy - s1y * wx;
        tn  = s2x * wy - s2y * wx;
        tol = {130'd0, tol_q30};
        r = '0;
        if (den == 0) begin
            r.parallel = 1'b1;
            return r;
        end
        if (den < 0) begin
            den = -den;
            sn  = -sn;
            tn  = -tn;
        end
        if (within_window(sn, den, tol) && within_window(tn, den, tol)) begin
            r.hit     = 1'b1;
            r.cross_x = point_coord(p1x, tn, s1x, den);
            r.cross_y = point_coord(p1y, tn, s1y, den);
        end
        return r;
    endfunction

    function automatic sip_pkg::sip_in_t seg_pair(int ax, int ay, int bx, int by,
                                                  int cx, int cy, int dx, int dy);
        sip_pkg::sip_in_t w;
        w.first_start_x  = ax;
        w.first_start_y  = ay;
        w.first_end_x    = bx;
        w.first_end_y    = by;
        w.second_start_x = cx;
        w.second_start_y = cy;
        w.second_end_x   = dx;
        w.second_end_y   = dy;
        return w;
    endfunction

    function automatic int small_coord();
        return int'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
    endfunction

    // Half crossings, parallel pairs and endpoint near misses, the rest full-range or small-range noise.
    function automatic sip_pkg::sip_in_t random_pair();
        int cx, cy, ux, uy, vx, vy, ox, oy;
        int unsigned kind;
        sip_pkg::sip_in_t w;
        kind = $urandom_range(0, 9);
        cx = small_coord();
        cy = small_coord();
        ux = small_coord();
        uy = small_coord();
        vx = small_coord();
        vy = small_coord();
        case (kind)
            0, 1: begin
                w = seg_pair($urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom, $urandom, $urandom);
            end
            2, 3, 4: begin
                w = seg_pair(cx - ux, cy - uy, cx + ux, cy + uy,
                             cx - vx, cy - vy, cx + vx, cy + vy);
            end
            5: begin
                // Parallel or collinear: the second segment is a shifted copy.
                ox = small_coord();
                oy = $urandom_range(0, 1) ? small_coord() : 0;
                if (oy == 0) ox = 0;
                w = seg_pair(cx, cy, cx + ux, cy + uy, cx + ox, cy + oy, cx + ox + ux, cy + oy + uy);
            end
            6: begin
                // Segments meeting at an endpoint, or just missing it.
                ox = int'($urandom_range(0, 4)) - 2;
                w = seg_pair(cx, cy, cx + ux, cy + uy,
                             cx + ux + ox, cy + uy, cx + ux + vx, cy + uy + vy);
            end
            default: begin
                w = seg_pair(small_coord(), small_coord(), small_coord(), small_coord(),
                             small_coord(), small_coord(), small_coord(), small_coord());
            end
        endcase
        return w;
    endfunction

    task automatic add_row(sip_pkg::sip_in_t w, bit typed, bit hit, bit par, int px, int py);
        stim_row_t row;
        row.w   = w;
        row.typed = typed;
        row.res = '{hit: hit, parallel: par, cross_x: px, cross_y: py};
        stim_table.push_back(row);
    endtask

    // Holds the word until it is taken, then records what it should produce.
    task automatic offer_word(sip_pkg::sip_in_t w, bit typed, sip_pkg::sip_out_t res,
                              bit may_idle);
        while (may_idle && $urandom_range(0, 99) < 30) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        pending_points.push_back(typed ? res : predict_crossing(w, tolerance));
    endtask

    task automatic write_tolerance(logic [sip_pkg::TolW-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        tolerance    = value;
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0) @(posedge aclk);
        repeat (DrainLen) @(posedge aclk);
    endtask

    // Receiver: random back-pressure, one long hold-off, an always-ready stretch, and result checking.
    always @(posedge aclk) begin
        sip_pkg::sip_out_t want;
        if (aresetn && m_valid && m_ready) begin
            words_out <= words_out + 1;
            if (pending_points.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word %p", m_data);
            end else begin
                want = pending_points.pop_front();
                if (m_data.hit !== want.hit || m_data.parallel !== want.parallel ||
                    m_data.cross_x !== want.cross_x || m_data.cross_y !== want.cross_y) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %p, got %p", want, m_data);
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!held && words_out >= 150) begin
            held      <= 1'b1;
            hold_left <= HoldLen;
            m_ready   <= 1'b0;
        end else if (words_out >= 250 && words_out < 330) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 30);
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WdLimit) begin
            $display("segment_intersection_point test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [sip_pkg::TolW-1:0] phase_tol[4];
        mismatches  = 0;
        words_out   = 0;
        idle_cycles = 0;
        held        = 1'b0;
        hold_left   = 0;
        tolerance   = sip_pkg::TolReset;
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        phase_tol   = '{30'd0, 30'h3FFF_FFFF, 30'd0, 30'd1};
        phase_tol[2] = 30'($urandom_range(0, 30'h3FFF_FFFF));

        add_row(seg_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 1, 0, 0);
        add_row(seg_pair(0, 0, 2*Q1, 2*Q1, 0, 2*Q1, 2*Q1, 0), 1, 1, 0, Q1, Q1);
        add_row(seg_pair(0, 0, 2*Q1, 0, 2*Q1, -Q1, 2*Q1, Q1), 1, 1, 0, 2*Q1, 0);
        add_row(seg_pair(0, 0, Q1, 0, 2*Q1, -Q1, 2*Q1, Q1), 1, 0, 0, 0, 0);
        add_row(seg_pair(MinC, 0, MaxC, 0, MinC, 1, MaxC, 1), 1, 0, 1, 0, 0);
        add_row(seg_pair(MinC, 0, MaxC, 0, MinC, 0, MaxC, 0), 1, 0, 1, 0, 0);
        add_row(seg_pair(Q1, Q1, Q1, Q1, 0, 0, 2*Q1, 2*Q1), 1, 0, 1, 0, 0);
        add_row(seg_pair(MinC, MinC, MaxC, MaxC, MinC, MaxC, MaxC, MinC), 0, 0, 0, 0, 0);
        add_row(seg_pair(MaxC, MaxC, MinC, MinC, MaxC, MinC, MinC, MaxC), 0, 0, 0, 0, 0);
        add_row(seg_pair(MaxC, MaxC, MaxC - 3, MaxC - 1, MaxC - 2, MaxC, MaxC, MaxC - 5),
                0, 0, 0, 0, 0);
        add_row(seg_pair(0, 0, 3, 0, 1, -1, 1, 2), 0, 0, 0, 0, 0);
        add_row(seg_pair(0, 0, 3, 1, 1, 7, 2, -5), 0, 0, 0, 0, 0);
        add_row(seg_pair(-1, -1, -1, -1, -1, -1, -1, -1), 1, 0, 1, 0, 0);
        add_row(seg_pair(32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA, 32'h5555_5555,
                         32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA, 32'hAAAA_AAAA),
                0, 0, 0, 0, 0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i])
            offer_word(stim_table[i].w, stim_table[i].typed, stim_table[i].res, 1);
        s_valid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < 4; ph++) begin
            write_tolerance(phase_tol[ph]);
            for (int n = 0; n < 100; n++)
                offer_word(random_pair(), 0, '0, !(n >= 40 && n < 75));
            s_valid <= 1'b0;
            wait_drained();
        end

        if (mismatches == 0 && pending_points.size() == 0) begin
            $display("segment_intersection_point test passed");
        end else begin
            $display("segment_intersection_point test failed");
        end
        $finish;
    end

endmodule

>>> files.f
design/sip_pkg.sv
design/sip_front.sv
design/sip_div.sv
design/sip_back.sv
design/segment_intersection_point.sv
dv/tb_segment_intersection_point.sv
